// ----- sv/fpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants for the failover permission policy block.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int ID_BITS_DEF = 60;
  localparam int TIME_W      = 64;
  localparam int MS32_W      = 32;
  localparam int CFG_IDX_W   = 2;

  // Verdict codes of the policy checks
  typedef enum logic [3:0] {
    VERDICT_OK           = 4'd0,
    VERDICT_NO_ID        = 4'd1,
    VERDICT_ID_CHANGED   = 4'd2,
    VERDICT_LINK_UP      = 4'd3,
    VERDICT_LINK_UNKNOWN = 4'd4,
    VERDICT_STALE        = 4'd5,
    VERDICT_DWELL        = 4'd6,
    VERDICT_IGN_OFF      = 4'd7,
    VERDICT_IGN_UNKNOWN  = 4'd8
  } verdict_t;

  // Request kinds carried on tuser
  typedef enum logic {
    REQ_EVALUATE = 1'b0,
    REQ_ACK      = 1'b1
  } req_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRESH_LIMIT   = 2'd0,
    CFG_DWELL_LIMIT   = 2'd1,
    CFG_IGN_REQUIRED  = 2'd2,
    CFG_IGN_UNKNOWN_OK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MS32_W-1:0] fresh_limit_ms;
    logic [MS32_W-1:0] dwell_limit_ms;
    logic              ignition_required;
    logic              ignition_unknown_ok;
  } cfg_t;

  // One request, identity travels beside it (its width is a parameter)
  typedef struct packed {
    req_kind_t         req_type;
    logic [TIME_W-1:0] now_ms;
    logic              id_known;
    logic              link_known;
    logic [MS32_W-1:0] link_age_ms;
    logic              link_up;
    logic              ign_known;
    logic              ign_on;
  } item_t;

  // Result, lowest field last so it packs into the low bits of tdata
  typedef struct packed {
    logic [MS32_W-1:0] revoke_total;
    logic [MS32_W-1:0] grant_total;
    logic [MS32_W-1:0] revoke_elapsed_ms;
    logic              revocation_waiting;
    logic              is_granted;
    verdict_t          verdict;
  } result_t;

  localparam int RES_BITS    = $bits(result_t);
  localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  // tdata bits of a request other than the identity
  localparam int IN_FIXED_BITS = TIME_W + MS32_W + 5;

endpackage

`default_nettype wire

// ----- sv/fpp_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fpp_cfg
  import fpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS32_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  // Write the addressed register, reset to policy defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fresh_limit_ms      <= 32'd30000;
      cfg.dwell_limit_ms      <= 32'd60000;
      cfg.ignition_required   <= 1'b1;
      cfg.ignition_unknown_ok <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRESH_LIMIT:    cfg.fresh_limit_ms      <= cfg_data;
        CFG_DWELL_LIMIT:    cfg.dwell_limit_ms      <= cfg_data;
        CFG_IGN_REQUIRED:   cfg.ignition_required   <= cfg_data[0];
        CFG_IGN_UNKNOWN_OK: cfg.ignition_unknown_ok <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/fpp_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_in_stage
// Input register: holds one request until the policy stage takes it.
// ----------------------------------------------------------------------------
module fpp_in_stage
  import fpp_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              item_in,
  input  logic [ID_BITS-1:0] id_in,
  input  logic               advance,
  output logic               hold_valid,
  output item_t              item_q,
  output logic [ID_BITS-1:0] id_q
);

  // Take a new request when empty or when the held one moves on
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_q <= item_in;
      id_q   <= id_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fpp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_core
// Policy state and the single-pass check chain for one request.
// ----------------------------------------------------------------------------
module fpp_core
  import fpp_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               step,
  input  item_t              item,
  input  logic [ID_BITS-1:0] id,
  output result_t            result
);

  logic               granted_flag, granted_flag_next;
  logic               pending_flag, pending_flag_next;
  logic [TIME_W-1:0]  revoked_time, revoked_time_next;
  logic [TIME_W-1:0]  down_start_time, down_start_time_next;
  logic [ID_BITS-1:0] held_identity, held_identity_next;
  logic [MS32_W-1:0]  grant_counter, grant_counter_next;
  logic [MS32_W-1:0]  revoke_counter, revoke_counter_next;

  verdict_t           verdict;
  logic [MS32_W-1:0]  elapsed;
  logic               revoke;
  logic [TIME_W-1:0]  since_revoke;
  logic [TIME_W-1:0]  down_span;
  logic               id_ok;
  logic               id_changed;

  // Time since revocation and continuous-down time; zero down start means not down
  assign since_revoke = (item.now_ms > revoked_time) ? item.now_ms - revoked_time : '0;
  assign down_span    = (down_start_time != '0 && item.now_ms > down_start_time)
                        ? item.now_ms - down_start_time : '0;
  assign id_ok        = item.id_known && (id != '0);
  assign id_changed   = (held_identity != '0) && (held_identity != id);

  // Run the check chain and form next state
  always_comb begin
    granted_flag_next    = granted_flag;
    pending_flag_next    = pending_flag;
    revoked_time_next    = revoked_time;
    down_start_time_next = down_start_time;
    held_identity_next   = held_identity;
    grant_counter_next   = grant_counter;
    revoke_counter_next  = revoke_counter;
    verdict              = VERDICT_OK;
    elapsed              = '0;
    revoke               = 1'b0;

    if (item.req_type == REQ_ACK) begin
      if (pending_flag) begin
        pending_flag_next = 1'b0;
        elapsed = (since_revoke[TIME_W-1:MS32_W] != '0) ? '1 : since_revoke[MS32_W-1:0];
      end
    end else if (!id_ok) begin
      verdict = VERDICT_NO_ID;
      revoke = 1'b1;
      down_start_time_next = '0;
    end else if (id_changed) begin
      verdict = VERDICT_ID_CHANGED;
      revoke = 1'b1;
      down_start_time_next = '0;
      held_identity_next = id;
    end else if (!item.link_known) begin
      verdict = VERDICT_LINK_UNKNOWN;
      revoke = 1'b1;
      down_start_time_next = '0;
    end else if (item.link_age_ms > cfg.fresh_limit_ms) begin
      verdict = VERDICT_STALE;
      revoke = 1'b1;
      down_start_time_next = '0;
    end else if (item.link_up) begin
      verdict = VERDICT_LINK_UP;
      revoke = 1'b1;
      down_start_time_next = '0;
    end else begin
      if (down_start_time == '0) begin
        down_start_time_next = item.now_ms;
      end
      if (down_span < {{(TIME_W-MS32_W){1'b0}}, cfg.dwell_limit_ms}) begin
        verdict = VERDICT_DWELL;
      end else if (cfg.ignition_required && !item.ign_known && !cfg.ignition_unknown_ok) begin
        verdict = VERDICT_IGN_UNKNOWN;
        revoke = 1'b1;
      end else if (cfg.ignition_required && item.ign_known && !item.ign_on) begin
        verdict = VERDICT_IGN_OFF;
        revoke = 1'b1;
      end else if (!granted_flag) begin
        granted_flag_next  = 1'b1;
        grant_counter_next = grant_counter + 32'd1;
        held_identity_next = id;
      end
    end

    // Withdraw a held grant and record when
    if (revoke && granted_flag) begin
      granted_flag_next   = 1'b0;
      pending_flag_next   = 1'b1;
      revoked_time_next   = item.now_ms;
      revoke_counter_next = revoke_counter + 32'd1;
    end
  end

  // Advance state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      granted_flag    <= 1'b0;
      pending_flag    <= 1'b0;
      revoked_time    <= '0;
      down_start_time <= '0;
      held_identity   <= '0;
      grant_counter   <= '0;
      revoke_counter  <= '0;
    end else if (step) begin
      granted_flag    <= granted_flag_next;
      pending_flag    <= pending_flag_next;
      revoked_time    <= revoked_time_next;
      down_start_time <= down_start_time_next;
      held_identity   <= held_identity_next;
      grant_counter   <= grant_counter_next;
      revoke_counter  <= revoke_counter_next;
    end
  end

  // Result fields show state after this request
  always_comb begin
    result.verdict            = verdict;
    result.is_granted         = granted_flag_next;
    result.revocation_waiting = pending_flag_next;
    result.revoke_elapsed_ms  = elapsed;
    result.grant_total        = grant_counter_next;
    result.revoke_total       = revoke_counter_next;
  end

endmodule

`default_nettype wire

// ----- sv/fpp_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module fpp_out_stage
  import fpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    hold_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_q
);

  // Move a request forward when the result slot is free or being drained
  assign advance = hold_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

endmodule

`default_nettype wire

// ----- sv/failover_permission_policy.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// failover_permission_policy
// Grants or revokes backup-link takeover from identity, link and ignition
// status; acknowledges revocations with the elapsed time.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Content
// s_*      | in  | s_tvalid/s_tready  | tdata: request fields, tuser: request kind
// m_*      | out | m_tvalid/m_tready  | tdata: result fields
// cfg_*    | in  | cfg_we             | register index and write data
//
// One request per cycle while the result is not stalled; each passes through
// the input register, then the check chain into the result register.
// The longest path is the 64-bit down-time subtract and dwell compare.
// Reset is synchronous and clears policy state and configuration to defaults.
// A stalled result holds; one more request is taken into the input register.
// ----------------------------------------------------------------------------
module failover_permission_policy
  import fpp_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int IN_BITS    = IN_FIXED_BITS + ID_BITS,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // now_ms[63:0], id_known, id_value[ID_BITS], link_known, link_age_ms[32],
  // link_up, ign_known, ign_on, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // verdict[4], is_granted, revocation_waiting, revoke_elapsed_ms[32],
  // grant_total[32], revoke_total[32], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [MS32_W-1:0]      cfg_data
);

  localparam int ID_LO   = TIME_W + 1;
  localparam int LINK_LO = ID_LO + ID_BITS;

  cfg_t               cfg;
  item_t              item_in;
  item_t              item_q;
  logic [ID_BITS-1:0] id_in;
  logic [ID_BITS-1:0] id_q;
  logic               hold_valid;
  logic               advance;
  result_t            result;
  result_t            result_q;

  // Unpack the request
  always_comb begin
    item_in.req_type    = req_kind_t'(s_tuser);
    item_in.now_ms      = s_tdata[TIME_W-1:0];
    item_in.id_known    = s_tdata[TIME_W];
    item_in.link_known  = s_tdata[LINK_LO];
    item_in.link_age_ms = s_tdata[LINK_LO+1 +: MS32_W];
    item_in.link_up     = s_tdata[LINK_LO+1+MS32_W];
    item_in.ign_known   = s_tdata[LINK_LO+2+MS32_W];
    item_in.ign_on      = s_tdata[LINK_LO+3+MS32_W];
  end
  assign id_in = s_tdata[ID_LO +: ID_BITS];

  fpp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpp_in_stage #(.ID_BITS(ID_BITS)) u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item_in    (item_in),
    .id_in      (id_in),
    .advance    (advance),
    .hold_valid (hold_valid),
    .item_q     (item_q),
    .id_q       (id_q)
  );

  fpp_core #(.ID_BITS(ID_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item_q),
    .id     (id_q),
    .result (result)
  );

  fpp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result_q   (result_q)
  );

  // Pack the result, zero filled to whole bytes
  assign m_tdata = {{(OUT_TDATA_W-RES_BITS){1'b0}}, result_q};

endmodule

`default_nettype wire

// ----- sv/fpp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_checker
// Port-level checks for the failover permission policy block.
// ----------------------------------------------------------------------------
module fpp_checker
  import fpp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Input only backs up behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // Elapsed time comes only from an acknowledge, which clears the waiting flag
  a_elapsed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37:6] != 32'd0 |-> m_tdata[3:0] == VERDICT_OK && !m_tdata[5])
    else $error("elapsed time on a non-acknowledge result");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind failover_permission_policy fpp_checker u_fpp_checker (.*);

`default_nettype wire

// ----- tb/sv/failover_permission_policy_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failover_permission_policy_tb
// Drives evaluate and acknowledge requests into the failover permission
// policy block under random stalls on both streams, with register settings
// changed between phases. A behavioral predictor in the scoreboard works out
// each result, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module failover_permission_policy_tb;
  import fpp_pkg::*;

  localparam int ID_W        = ID_BITS_DEF;
  localparam int IN_W        = ((IN_FIXED_BITS + ID_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 64;
  localparam int PHASE_ITEMS = 200;

  // One request as the sender builds it
  typedef struct packed {
    req_kind_t         kind;
    logic [TIME_W-1:0] now;
    logic              id_known;
    logic [ID_W-1:0]   id;
    logic              link_known;
    logic [MS32_W-1:0] link_age;
    logic              link_up;
    logic              ign_known;
    logic              ign_on;
  } policy_req_t;

  // Predicts the takeover decision and holds the results still to come
  class policy_scoreboard;
    cfg_t              cfg;
    bit                grant_held;
    bit                revoke_waiting;
    logic [TIME_W-1:0] revoke_stamp;
    logic [TIME_W-1:0] down_since;
    logic [ID_W-1:0]   id_held;
    logic [31:0]       grants;
    logic [31:0]       revokes;
    result_t           outcomes[$];
    int                errors;

    function new();
      cfg.fresh_limit_ms      = 32'd30000;
      cfg.dwell_limit_ms      = 32'd60000;
      cfg.ignition_required   = 1'b1;
      cfg.ignition_unknown_ok = 1'b0;
      grant_held     = 0;
      revoke_waiting = 0;
      revoke_stamp   = '0;
      down_since     = '0;
      id_held        = '0;
      grants         = '0;
      revokes        = '0;
      errors         = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_FRESH_LIMIT:    cfg.fresh_limit_ms      = val;
        CFG_DWELL_LIMIT:    cfg.dwell_limit_ms      = val;
        CFG_IGN_REQUIRED:   cfg.ignition_required   = val[0];
        CFG_IGN_UNKNOWN_OK: cfg.ignition_unknown_ok = val[0];
        default: ;
      endcase
    endfunction

    // Revoke only a grant that is actually held
    function void drop_grant(logic [TIME_W-1:0] now);
      if (grant_held) begin
        grant_held     = 0;
        revoke_waiting = 1;
        revoke_stamp   = now;
        revokes        = revokes + 1;
      end
    endfunction

    // Run the check chain; first failure decides the verdict
    function verdict_t judge(policy_req_t r);
      logic [TIME_W-1:0] down_span;
      if (!r.id_known || r.id == '0) begin
        drop_grant(r.now);
        down_since = '0;
        return VERDICT_NO_ID;
      end
      if (id_held != '0 && id_held != r.id) begin
        drop_grant(r.now);
        down_since = '0;
        id_held    = r.id;
        return VERDICT_ID_CHANGED;
      end
      if (!r.link_known) begin
        drop_grant(r.now);
        down_since = '0;
        return VERDICT_LINK_UNKNOWN;
      end
      if (r.link_age > cfg.fresh_limit_ms) begin
        drop_grant(r.now);
        down_since = '0;
        return VERDICT_STALE;
      end
      if (r.link_up) begin
        drop_grant(r.now);
        down_since = '0;
        return VERDICT_LINK_UP;
      end
      // A start taken at time zero reads as not down next time
      if (down_since == '0) down_since = r.now;
      down_span = (r.now > down_since) ? r.now - down_since : '0;
      if (down_span < {32'd0, cfg.dwell_limit_ms}) return VERDICT_DWELL;
      if (cfg.ignition_required) begin
        if (!r.ign_known) begin
          if (!cfg.ignition_unknown_ok) begin
            drop_grant(r.now);
            return VERDICT_IGN_UNKNOWN;
          end
        end else if (!r.ign_on) begin
          drop_grant(r.now);
          return VERDICT_IGN_OFF;
        end
      end
      if (!grant_held) begin
        grant_held = 1;
        grants     = grants + 1;
        id_held    = r.id;
      end
      return VERDICT_OK;
    endfunction

    function void note_request(policy_req_t r);
      result_t           res;
      logic [TIME_W-1:0] since;
      res = '0;
      res.verdict = VERDICT_OK;
      if (r.kind == REQ_ACK) begin
        if (revoke_waiting) begin
          revoke_waiting = 0;
          if (r.now > revoke_stamp) begin
            since = r.now - revoke_stamp;
            res.revoke_elapsed_ms = (since > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : since[31:0];
          end
        end
      end else begin
        res.verdict = judge(r);
      end
      res.is_granted         = grant_held;
      res.revocation_waiting = revoke_waiting;
      res.grant_total        = grants;
      res.revoke_total       = revokes;
      outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (outcomes.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = outcomes.pop_front();
      compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
      compare_field("is_granted", 32'(want.is_granted), 32'(got.is_granted));
      compare_field("revocation_waiting", 32'(want.revocation_waiting),
                    32'(got.revocation_waiting));
      compare_field("revoke_elapsed_ms", want.revoke_elapsed_ms, got.revoke_elapsed_ms);
      compare_field("grant_total", want.grant_total, got.grant_total);
      compare_field("revoke_total", want.revoke_total, got.revoke_total);
    endfunction

    function int waiting();
      return outcomes.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [MS32_W-1:0]      cfg_data = '0;

  policy_scoreboard board = new();

  bit                tx_calm;
  bit                rx_calm;
  bit                long_hold;
  int                cycles = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   id_pool[3];
  logic [31:0]       fresh_sel;
  logic [31:0]       dwell_sel;

  failover_permission_policy u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic policy_req_t eval_req(logic [TIME_W-1:0] now, logic id_known,
                                           logic [ID_W-1:0] id, logic link_known,
                                           logic [31:0] age, logic link_up,
                                           logic ign_known, logic ign_on);
    policy_req_t r;
    r.kind       = REQ_EVALUATE;
    r.now        = now;
    r.id_known   = id_known;
    r.id         = id;
    r.link_known = link_known;
    r.link_age   = age;
    r.link_up    = link_up;
    r.ign_known  = ign_known;
    r.ign_on     = ign_on;
    return r;
  endfunction

  function automatic policy_req_t ack_req(logic [TIME_W-1:0] now);
    policy_req_t r;
    r = '0;
    r.kind = REQ_ACK;
    r.now  = now;
    return r;
  endfunction

  // Mostly well-formed status from one device with advancing time, plus noise
  function automatic policy_req_t next_request();
    policy_req_t       r;
    int                roll;
    logic [TIME_W-1:0] advance;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.kind       = req_kind_t'($urandom_range(0, 1));
      r.now        = {$urandom, $urandom};
      r.id_known   = 1'($urandom_range(0, 1));
      r.id         = ($urandom_range(0, 7) == 0) ? '0 : ID_W'({$urandom, $urandom});
      r.link_known = 1'($urandom_range(0, 1));
      r.link_age   = $urandom;
      r.link_up    = 1'($urandom_range(0, 1));
      r.ign_known  = 1'($urandom_range(0, 1));
      r.ign_on     = 1'($urandom_range(0, 1));
      return r;
    end
    if (roll < 13) begin
      clock_ms = clock_ms + $urandom_range(0, 100);
      return ack_req(($urandom_range(0, 9) == 0) ? clock_ms - $urandom_range(0, 5000) : clock_ms);
    end
    advance = 64'($urandom) % (64'(dwell_sel) + 64'd1) + $urandom_range(0, 3);
    if ($urandom_range(0, 32) == 0 && clock_ms > 64'd2000) begin
      clock_ms = clock_ms - $urandom_range(0, 2000);
    end else begin
      clock_ms = clock_ms + advance;
    end
    r.kind       = REQ_EVALUATE;
    r.now        = clock_ms;
    r.id_known   = ($urandom_range(0, 49) != 0);
    r.id         = ($urandom_range(0, 32) == 0) ? id_pool[$urandom_range(1, 2)] : id_pool[0];
    if ($urandom_range(0, 49) == 0) r.id = '0;
    r.link_known = ($urandom_range(0, 49) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 4 && fresh_sel != 32'hFFFF_FFFF) r.link_age = fresh_sel + 1;
    else if (roll < 8) r.link_age = fresh_sel;
    else r.link_age = $urandom_range(0, fresh_sel);
    r.link_up    = ($urandom_range(0, 19) == 0);
    r.ign_known  = ($urandom_range(0, 11) != 0);
    r.ign_on     = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(policy_req_t r);
    int gap;
    gap = (!tx_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= IN_W'({r.ign_on, r.ign_known, r.link_up, r.link_age, r.link_known,
                       r.id, r.id_known, r.now});
    s_tuser  <= r.kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_request(r);
  endtask

  // Stop offering and wait for every outstanding result, then the pipeline
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers on an idle block
  task automatic apply_settings(logic [31:0] fresh, logic [31:0] dwell,
                                logic req_ign, logic unk_ok);
    cfg_idx_t    idxs[4];
    logic [31:0] vals[4];
    idxs = '{CFG_FRESH_LIMIT, CFG_DWELL_LIMIT, CFG_IGN_REQUIRED, CFG_IGN_UNKNOWN_OK};
    vals = '{fresh, dwell, {31'd0, req_ign}, {31'd0, unk_ok}};
    drain();
    cfg_we <= 1'b1;
    foreach (idxs[i]) begin
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      board.set_reg(idxs[i], vals[i]);
    end
    cfg_we    <= 1'b0;
    fresh_sel = fresh;
    dwell_sel = dwell;
  endtask

  // Accept results and stall the output at random
  initial begin : result_sink
    int hold;
    hold = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) board.check_result(result_t'(m_tdata[RES_BITS-1:0]));
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 0;
        hold = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        hold = pick_gap() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]   id_a;
    logic [ID_W-1:0]   id_b;
    logic [TIME_W-1:0] t_big;
    logic [31:0]       fresh;
    logic [31:0]       dwell;
    bit                req_ign;
    bit                unk_ok;

    tx_calm   = 1;
    rx_calm   = 1;
    long_hold = 0;
    fresh_sel = 32'd30000;
    dwell_sel = 32'd60000;
    id_a  = 60'h0A5_A5A5_A5A5_A5A5;
    id_b  = 60'h5A5_A5A5_A5A5_A5A6;
    t_big = 64'd210000 + (64'd1 << 40);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every verdict, grant and revoke paths, timing corners
    send_request(ack_req(64'd5));
    send_request(eval_req(64'd10, 1'b0, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd20, 1'b1, '0, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd30, 1'b1, id_a, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd40, 1'b1, id_a, 1'b1, 32'd30001, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd50, 1'b1, id_a, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1));
    // down start taken at time zero is not kept
    send_request(eval_req(64'd0, 1'b1, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd1000, 1'b1, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd61000, 1'b1, id_a, 1'b1, 32'd30000, 1'b0, 1'b0, 1'b1));
    send_request(eval_req(64'd61000, 1'b1, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0));
    send_request(eval_req(64'd62000, 1'b1, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd63000, 1'b1, id_a, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    // identity change revokes; acknowledge with the clock gone back
    send_request(eval_req(64'd64000, 1'b1, id_b, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(ack_req(64'd100));
    send_request(eval_req(64'd70000, 1'b1, id_b, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd130000, 1'b1, id_b, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    // ignition failure revokes but keeps the dwell start
    send_request(eval_req(64'd140000, 1'b1, id_b, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
    send_request(eval_req(64'd200000, 1'b1, id_b, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_request(eval_req(64'd210000, 1'b1, id_b, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1));
    // elapsed time beyond 32 bits saturates; a second acknowledge reads zero
    send_request(ack_req(t_big));
    send_request(ack_req(t_big));
    send_request(eval_req('1, 1'b1, '1, 1'b1, '1, 1'b1, 1'b1, 1'b1));
    send_request(eval_req('1, 1'b1, '1, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
    drain();

    // Random phases, each with its own register settings
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin fresh = 32'd30000;     dwell = 32'd60000;     req_ign = 1; unk_ok = 0; end
        1: begin fresh = 32'd0;         dwell = 32'd0;         req_ign = 0; unk_ok = 0; end
        2: begin fresh = 32'hFFFF_FFFF; dwell = 32'hFFFF_FFFF; req_ign = 1; unk_ok = 1; end
        3: begin fresh = $urandom_range(0, 5000); dwell = $urandom_range(0, 20000);
                 req_ign = 1; unk_ok = 1; end
        4: begin fresh = $urandom; dwell = $urandom_range(0, 2000); req_ign = 1; unk_ok = 0; end
        5: begin fresh = $urandom; dwell = $urandom_range(0, 100000);
                 req_ign = 0; unk_ok = 1; end
        default: begin fresh = $urandom_range(0, 60000); dwell = $urandom_range(0, 60000);
                 req_ign = 1'($urandom_range(0, 1)); unk_ok = 1'($urandom_range(0, 1)); end
      endcase
      apply_settings(fresh, dwell, req_ign, unk_ok);
      clock_ms = ($urandom_range(0, 1) == 0) ? 64'd1 + $urandom_range(0, 1000)
                 : {1'b0, $urandom, 31'($urandom_range(0, 31'h7FFF_FFFF))};
      foreach (id_pool[k]) id_pool[k] = ID_W'({$urandom, $urandom}) | 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        tx_calm = (n < 40);
        rx_calm = (n < 40);
        // hold the output off while requests keep coming, so the input stalls
        if (phase == 1 && n == 60) long_hold = 1;
        if (phase == 1 && n >= 60 && n < 90) tx_calm = 1;
        if (phase == 3 && n == 100) drain();
        send_request(next_request());
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- failover_permission_policy.f -----
sv/fpp_pkg.sv
sv/fpp_cfg.sv
sv/fpp_in_stage.sv
sv/fpp_core.sv
sv/fpp_out_stage.sv
sv/failover_permission_policy.sv
sv/fpp_checker.sv
tb/sv/failover_permission_policy_tb.sv
